>>> hdl/pcd_pkg.sv
// pcd_pkg: shared constants, register indexes and controller/datapath structs
// for the pedal cadence detector
// no dependencies
`default_nettype none

package pcd_pkg;

    // history and time widths
    localparam int HISTORY_DEPTH = 10;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int AVG_W         = 16;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);

    // radix-4 divider, two quotient bits per step
    localparam int DIV_STEPS = TIME_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = 1 + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + AVG_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE   = 2'd3;

    // configuration reset values
    localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd333;
    localparam logic [CFG_W-1:0] STALE_RST   = 16'd1500;
    localparam logic [CFG_W-1:0] SEED_RST    = 16'd857;
    localparam logic [CFG_W-1:0] GRACE_RST   = 16'd500;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic span;
        logic div_step;
        logic avg_load;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pulse;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/pedal_cadence_detector.sv
// pedal_cadence_detector: a sample with no accepted pulse goes from input
// capture through evaluation to the output register; an accepted pulse also
// has its average recomputed by a radix-4 divider of 16 iterations.
// One sample at a time: the next sample is taken only once the previous result
// is in the output register, and it may be taken while that result waits there.
// aresetn (synchronous) clears control state and loads register defaults.
`default_nettype none

module pedal_cadence_detector (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [pcd_pkg::CFG_IDX_W-1:0]     cfg_wr_idx,
    input  wire logic [pcd_pkg::CFG_W-1:0]         cfg_wr_data,
    // input samples
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pcd_pkg::S_TDATA_W-1:0]     s_tdata,  // pin_level, now_ms
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pcd_pkg::M_TDATA_W-1:0]          m_tdata   // is_pedalling, average_ms
);

    pcd_pkg::cmd_t    cmd;
    pcd_pkg::status_t status;
    logic                       out_pedalling;
    logic [pcd_pkg::AVG_W-1:0]  out_average;

    // sequencing
    pcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    pcd_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_idx    (cfg_wr_idx),
        .cfg_wr_data   (cfg_wr_data),
        .in_level      (s_tdata[0]),
        .in_now        (s_tdata[pcd_pkg::TIME_W:1]),
        .cmd           (cmd),
        .status        (status),
        .out_pedalling (out_pedalling),
        .out_average   (out_average)
    );

    // pack result fields
    assign m_tdata = {{(pcd_pkg::M_TDATA_W - pcd_pkg::M_FIELDS_W){1'b0}},
                      out_average, out_pedalling};

endmodule

`default_nettype wire

>>> hdl/pcd_datapath.sv
// pcd_datapath: configuration registers, pulse history shift line, sample
// evaluation, radix-4 interval divider and output payload register
// depends on pcd_pkg
`default_nettype none

module pcd_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pcd_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  wire logic [pcd_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic                            in_level,
    input  wire logic [pcd_pkg::TIME_W-1:0]      in_now,
    input  wire pcd_pkg::cmd_t                   cmd,
    output pcd_pkg::status_t                     status,
    output logic                                 out_pedalling,
    output logic [pcd_pkg::AVG_W-1:0]            out_average
);

    localparam int TW = pcd_pkg::TIME_W;
    localparam int CW = pcd_pkg::CNT_W;
    localparam int D  = pcd_pkg::HISTORY_DEPTH;

    logic [pcd_pkg::CFG_W-1:0] lockout_reg, stale_reg, seed_reg, grace_reg;
    logic [TW-1:0] times_reg [D];
    logic [CW-1:0] count_reg;
    logic          prev_reg;
    logic [TW-1:0] last_reg;
    logic          flag_reg;
    logic [pcd_pkg::AVG_W-1:0] avg_reg;
    logic          lvl_reg;
    logic [TW-1:0] now_reg;
    logic [TW-1:0] dvd_reg;
    logic [CW-1:0] rem_reg;
    logic          out_ped_reg;
    logic [pcd_pkg::AVG_W-1:0] out_avg_reg;

    logic [TW-1:0] since_last, gap, avg_plus;
    logic          lock, rise, stale, has_two, flag_next;
    logic [CW-1:0] count_next, divisor;
    logic [pcd_pkg::IDX_W-1:0] oldest_idx;
    logic [CW+1:0] trial, d1, d2, d3, sub;
    logic [1:0]    digit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_reg <= pcd_pkg::LOCKOUT_RST;
            stale_reg   <= pcd_pkg::STALE_RST;
            seed_reg    <= pcd_pkg::SEED_RST;
            grace_reg   <= pcd_pkg::GRACE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                pcd_pkg::REG_LOCKOUT: lockout_reg <= cfg_wr_data;
                pcd_pkg::REG_STALE:   stale_reg   <= cfg_wr_data;
                pcd_pkg::REG_SEED:    seed_reg    <= cfg_wr_data;
                pcd_pkg::REG_GRACE:   grace_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sample evaluation on the captured input
    always_comb begin
        since_last = now_reg - last_reg;
        lock       = since_last < {{(TW-pcd_pkg::CFG_W){1'b0}}, lockout_reg};
        rise       = !prev_reg && lvl_reg;
        gap        = now_reg - times_reg[0];
        stale      = (count_reg == '0) ||
                     (gap > {{(TW-pcd_pkg::CFG_W){1'b0}}, stale_reg});
        has_two    = count_reg >= CW'(2);
        avg_plus   = {{(TW-pcd_pkg::AVG_W){1'b0}}, avg_reg} +
                     {{(TW-pcd_pkg::CFG_W){1'b0}}, grace_reg};
        priority if (lock || rise) begin
            flag_next = 1'b1;
        end else if (!has_two) begin
            flag_next = 1'b0;
        end else begin
            flag_next = gap <= avg_plus;
        end
        count_next = (count_reg == CW'(D)) ? CW'(D) : count_reg + CW'(1);
        status.pulse = !lock && rise;
    end

    // history, pulse time and pedalling state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            prev_reg  <= 1'b0;
            last_reg  <= '0;
            flag_reg  <= 1'b0;
        end else if (cmd.eval) begin
            prev_reg <= lvl_reg;
            flag_reg <= flag_next;
            if (status.pulse) begin
                last_reg <= now_reg;
                if (stale) begin
                    count_reg <= CW'(2);
                end else begin
                    count_reg <= count_next;
                end
            end
        end
    end

    // history shift line, newest entry at index 0
    always_ff @(posedge aclk) begin
        if (cmd.eval && status.pulse) begin
            times_reg[0] <= now_reg;
            if (stale) begin
                times_reg[1] <= now_reg - {{(TW-pcd_pkg::CFG_W){1'b0}}, seed_reg};
            end else begin
                for (int i = 1; i < D; i++) begin
                    times_reg[i] <= times_reg[i-1];
                end
            end
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lvl_reg <= in_level;
            now_reg <= in_now;
        end
    end

    // divider step: two quotient bits per cycle, divisor is count minus one
    always_comb begin
        divisor    = count_reg - CW'(1);
        oldest_idx = divisor[pcd_pkg::IDX_W-1:0];
        d1    = {2'b00, divisor};
        d2    = {1'b0, divisor, 1'b0};
        d3    = d1 + d2;
        trial = {rem_reg, dvd_reg[TW-1 -: 2]};
        priority if (trial >= d3) begin
            digit = 2'd3;
            sub   = trial - d3;
        end else if (trial >= d2) begin
            digit = 2'd2;
            sub   = trial - d2;
        end else if (trial >= d1) begin
            digit = 2'd1;
            sub   = trial - d1;
        end else begin
            digit = 2'd0;
            sub   = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.span) begin
            dvd_reg <= times_reg[0] - times_reg[oldest_idx];
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[TW-3:0], digit};
            rem_reg <= sub[CW-1:0];
        end
    end

    // cached average, saturated to 16 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (cmd.avg_load) begin
            avg_reg <= (|dvd_reg[TW-1:pcd_pkg::AVG_W]) ? '1 : dvd_reg[pcd_pkg::AVG_W-1:0];
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ped_reg <= flag_reg;
            out_avg_reg <= has_two ? avg_reg : '0;
        end
    end

    assign out_pedalling = out_ped_reg;
    assign out_average   = out_avg_reg;

endmodule

`default_nettype wire

>>> hdl/pcd_ctrl.sv
// pcd_ctrl: sequencing state machine, divider step counter and output valid
// depends on pcd_pkg
`default_nettype none

module pcd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire pcd_pkg::status_t   status,
    output pcd_pkg::cmd_t           cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_SPAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [pcd_pkg::STEP_W-1:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.pulse ? ST_SPAN : ST_DONE;
            end
            ST_SPAN: begin
                cmd.span   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + pcd_pkg::STEP_W'(1);
                if (step_reg == pcd_pkg::STEP_W'(pcd_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.avg_load = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the transaction completes
    always_comb begin
        priority if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> tb/sv/pedal_cadence_checker.sv
// pedal_cadence_checker: watches the sample, result and register write ports,
// predicts each result of the pedal cadence detector and compares it
// depends on pcd_pkg for widths and register indexes
`timescale 1ns / 1ps

module pedal_cadence_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]     cfg_wr_idx,
    input  logic [pcd_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [pcd_pkg::S_TDATA_W-1:0]     s_tdata,   // pin_level, now_ms
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pcd_pkg::M_TDATA_W-1:0]     m_tdata,   // is_pedalling, average_ms
    output int                                mismatch_count,
    output int                                pending_results
);
    import pcd_pkg::*;

    typedef struct packed {
        logic              pedalling;
        logic [AVG_W-1:0]  average_ms;
    } cadence_t;

    // register copies
    logic [CFG_W-1:0]  lockout_cfg;
    logic [CFG_W-1:0]  stale_cfg;
    logic [CFG_W-1:0]  seed_cfg;
    logic [CFG_W-1:0]  grace_cfg;

    // predicted detector state
    logic [TIME_W-1:0] pulse_history [HISTORY_DEPTH];
    int                pulse_total;
    logic              prev_pin;
    logic [TIME_W-1:0] last_pulse_at;
    logic              pedalling_now;

    // expected results, oldest first
    cadence_t          cadence_queue [$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // mean pulse interval over the history, saturated to the output width
    function automatic logic [AVG_W-1:0] history_average();
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] quotient;
        if (pulse_total < 2) begin
            return '0;
        end
        span     = pulse_history[pulse_total-1] - pulse_history[0];
        quotient = span / TIME_W'(pulse_total - 1);
        if (quotient > TIME_W'(65535)) begin
            return '1;
        end
        return quotient[AVG_W-1:0];
    endfunction

    // append a pulse time, dropping the oldest when full
    function automatic void record_pulse(input logic [TIME_W-1:0] at_ms);
        if (pulse_total >= HISTORY_DEPTH) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                pulse_history[i] = pulse_history[i+1];
            end
            pulse_total = HISTORY_DEPTH - 1;
        end
        pulse_history[pulse_total] = at_ms;
        pulse_total++;
    endfunction

    // one sensor sample: update the state and give the reported cadence
    function automatic cadence_t step_cadence(input logic pin,
                                              input logic [TIME_W-1:0] now_ms);
        logic [TIME_W-1:0] since_pulse;
        logic [TIME_W-1:0] since_newest;
        logic [TIME_W-1:0] hold_limit;
        cadence_t          reading;
        since_pulse = now_ms - last_pulse_at;
        if (since_pulse < TIME_W'(lockout_cfg)) begin
            // lockout after a pulse: treat as bounce
            pedalling_now = 1'b1;
        end else if (!prev_pin && pin) begin
            pedalling_now = 1'b1;
            // empty or stale history restarts one nominal period back
            if (pulse_total != 0) begin
                since_newest = now_ms - pulse_history[pulse_total-1];
                if (since_newest > TIME_W'(stale_cfg)) begin
                    pulse_total = 0;
                end
            end
            if (pulse_total == 0) begin
                record_pulse(now_ms - TIME_W'(seed_cfg));
            end
            record_pulse(now_ms);
            last_pulse_at = now_ms;
        end else if (pulse_total < 2) begin
            pedalling_now = 1'b0;
        end else begin
            since_newest  = now_ms - pulse_history[pulse_total-1];
            hold_limit    = TIME_W'(history_average()) + TIME_W'(grace_cfg);
            pedalling_now = (since_newest <= hold_limit);
        end
        prev_pin           = pin;
        reading.pedalling  = pedalling_now;
        reading.average_ms = history_average();
        return reading;
    endfunction

    always @(posedge aclk) begin : monitor
        cadence_t seen;
        cadence_t want;
        if (!aresetn) begin
            lockout_cfg    = LOCKOUT_RST;
            stale_cfg      = STALE_RST;
            seed_cfg       = SEED_RST;
            grace_cfg      = GRACE_RST;
            pulse_total    = 0;
            prev_pin       = 1'b0;
            last_pulse_at  = '0;
            pedalling_now  = 1'b0;
            mismatch_count = 0;
            cadence_queue.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                seen.pedalling  = m_tdata[0];
                seen.average_ms = m_tdata[AVG_W:1];
                if (cadence_queue.size() == 0) begin
                    report_mismatch("result with no sample pending", 32'(seen), 0);
                end else begin
                    want = cadence_queue.pop_front();
                    if (seen.pedalling !== want.pedalling) begin
                        report_mismatch("is_pedalling", 32'(seen.pedalling),
                                        32'(want.pedalling));
                    end
                    if (seen.average_ms !== want.average_ms) begin
                        report_mismatch("average_ms", 32'(seen.average_ms),
                                        32'(want.average_ms));
                    end
                end
            end
            // sample transaction
            if (s_tvalid && s_tready) begin
                cadence_queue.insert(cadence_queue.size(),
                                     step_cadence(s_tdata[0], s_tdata[TIME_W:1]));
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_wr_idx)
                    REG_LOCKOUT: lockout_cfg = cfg_wr_data;
                    REG_STALE:   stale_cfg   = cfg_wr_data;
                    REG_SEED:    seed_cfg    = cfg_wr_data;
                    REG_GRACE:   grace_cfg   = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pending_results = cadence_queue.size();
    end

endmodule

>>> tb/sv/pedal_cadence_detector_test.sv
// pedal_cadence_detector_test: clock, reset and sensor sample stimulus for the
// pedal cadence detector, with pedal_cadence_checker beside it for the verdict
// depends on pcd_pkg, pedal_cadence_detector and pedal_cadence_checker
`timescale 1ns / 1ps

module pedal_cadence_detector_test;
    import pcd_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_SAMPLES = 305;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // pin_level, now_ms
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // is_pedalling, average_ms

    int                    mismatch_count;
    int                    pending_results;

    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    bit                    hold_req;
    int                    samples_sent;
    logic [31:0]           clock_ms;

    pedal_cadence_detector u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    pedal_cadence_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_idx      (cfg_wr_idx),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ends the run when no transaction happens for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("pedal_cadence_detector_test failed");
        $finish;
    end

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic pin, input logic [31:0] at_ms);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({at_ms, pin});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
    endtask

    // stop offering samples until every result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic write_registers(input logic [CFG_W-1:0] lockout, input logic [CFG_W-1:0] stale,
                                   input logic [CFG_W-1:0] seed, input logic [CFG_W-1:0] grace);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= REG_LOCKOUT;
        cfg_wr_data <= lockout;
        @(negedge aclk);
        cfg_wr_idx  <= REG_STALE;
        cfg_wr_data <= stale;
        @(negedge aclk);
        cfg_wr_idx  <= REG_SEED;
        cfg_wr_data <= seed;
        @(negedge aclk);
        cfg_wr_idx  <= REG_GRACE;
        cfg_wr_data <= grace;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // steady pedalling: edge, optional bounce, low samples within the period
    task automatic pedal_run();
        int unsigned period;
        int unsigned pulses;
        period = $urandom_range(120, 1800);
        pulses = $urandom_range(3, 14);
        repeat (pulses) begin
            send_sample(1'b1, clock_ms);
            if ($urandom_range(3) == 0) begin
                send_sample(1'b0, clock_ms + 2);
                send_sample(1'b1, clock_ms + 4);
            end
            send_sample(1'b0, clock_ms + $urandom_range(10, period / 2));
            if ($urandom_range(1) == 0) begin
                send_sample(1'b0, clock_ms + period - 5);
            end
            clock_ms = clock_ms + period + $urandom_range(0, 80) - 40;
        end
    endtask

    // mostly pedal runs, then coasting, noise and time jumps
    task automatic random_burst();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (pick < 65) begin
            pedal_run();
        end else if (pick < 80) begin
            n = $urandom_range(2, 5);
            repeat (n) begin
                clock_ms = clock_ms + $urandom_range(100, 3000);
                send_sample(1'b0, clock_ms);
            end
        end else if (pick < 93) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                clock_ms = clock_ms + $urandom_range(0, 70000);
                send_sample(1'($urandom_range(1)), clock_ms);
            end
        end else begin
            if ($urandom_range(1) == 0) begin
                clock_ms = $urandom();
            end else begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
            end
            send_sample(1'($urandom_range(1)), clock_ms);
        end
    endtask

    initial begin : stimulus
        int  phase_goal;
        bit  hold_done;
        bit  paused;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_idx    = REG_LOCKOUT;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        paused        = 1'b0;
        samples_sent  = 0;
        send_idle_pct = 32;
        recv_idle_pct = 76;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed samples with the reset register values
        send_sample(1'b1, 32'd0);            // lockout right after reset
        send_sample(1'b0, 32'd200);
        send_sample(1'b0, 32'd400);          // too few pulses
        send_sample(1'b1, 32'd1000);         // empty history is seeded
        send_sample(1'b0, 32'd1100);
        send_sample(1'b1, 32'd1200);         // edge inside lockout ignored
        send_sample(1'b0, 32'd1400);         // still within average plus grace
        send_sample(1'b1, 32'd1800);
        send_sample(1'b0, 32'd2000);
        send_sample(1'b0, 32'd3200);         // gap too long, stopped
        send_sample(1'b1, 32'd4000);         // stale history restarts
        send_sample(1'b0, 32'd4400);
        send_sample(1'b1, 32'hFFFF_FF00);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0200);    // pulse across the wrap
        send_sample(1'b0, 32'h0000_0400);
        send_sample(1'b0, 32'hFFFF_FFFF);    // time going back
        send_sample(1'b1, 32'd845);          // edge exactly at end of lockout
        send_sample(1'b0, 32'd1177);         // last millisecond of lockout
        send_sample(1'b1, 32'd2345);         // gap equal to the stale limit
        drain_results();
        clock_ms = 32'd4000;

        for (int phase = 0; phase < 6; phase++) begin
            phase_goal = samples_sent + PHASE_SAMPLES;
            case (phase / 2)
                0: begin send_idle_pct = 32; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                1, 4: write_registers(CFG_W'($urandom_range(50, 600)),
                                      CFG_W'($urandom_range(800, 5000)),
                                      CFG_W'($urandom_range(200, 2000)),
                                      CFG_W'($urandom_range(0, 1500)));
                2: write_registers('0, '0, '0, '0);
                3: write_registers('1, '1, '1, '1);
                5: write_registers(CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)));
                default: ;
            endcase
            while (samples_sent < phase_goal) begin
                // long result stall while samples keep coming
                if (phase == 0 && !hold_done && samples_sent > phase_goal - 200) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                // sender pause until everything is out
                if (phase == 3 && !paused && samples_sent > phase_goal - 150) begin
                    drain_results();
                    paused = 1'b1;
                end
                random_burst();
            end
            drain_results();
        end

        repeat (30) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("pedal_cadence_detector_test passed");
        end else begin
            $display("pedal_cadence_detector_test failed");
        end
        $finish;
    end

endmodule
